[hdl/takeoff_init_sequencer_macros.svh]
// Assertion helpers for the takeoff and init sequencer.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef TAKEOFF_INIT_SEQUENCER_MACROS_SVH
`define TAKEOFF_INIT_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TIS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/tis_pkg.sv]
`default_nettype none

package tis_pkg;

	// Sequencer stages.
	typedef enum logic [2:0] {
		ST_IDLE        = 3'd0,
		ST_STARTED     = 3'd1,
		ST_WAIT_FIRST  = 3'd2,
		ST_TOOK_FIRST  = 3'd3,
		ST_WAIT_SECOND = 3'd4,
		ST_DONE        = 3'd5
	} stage_t;

	// Drive choices reported with each result.
	typedef enum logic [1:0] {
		DRV_HOVER   = 2'd0,
		DRV_CLIMB   = 2'd1,
		DRV_DESCEND = 2'd2,
		DRV_CTRL    = 2'd3
	} drive_t;

	// Register map: index is paddr[3:2].
	localparam int unsigned APB_AW = 4;
	typedef enum logic [1:0] {
		REG_INIT_MODE = 2'd0,
		REG_MOVE_TIME = 2'd1,
		REG_WAIT_TIME = 2'd2,
		REG_UNUSED    = 2'd3
	} reg_idx_t;

	// Fixed timing in milliseconds.
	localparam logic [31:0] PLAIN_WAIT_MS  = 32'd5000;
	localparam logic [31:0] CLIMB_WAIT_MS  = 32'd6000;
	localparam logic [31:0] FIRST_WAIT_MS  = 32'd1000;
	localparam logic [31:0] SECOND_WAIT_MS = 32'd2500;

	// Reset values of the configuration registers.
	localparam logic        INIT_MODE_RST = 1'b1;
	localparam logic [15:0] MOVE_TIME_RST = 16'd1000;
	localparam logic [15:0] WAIT_TIME_RST = 16'd1000;

	// Tracker status code for a tracker that is still initializing.
	localparam logic [2:0] TRK_INITIALIZING = 3'd0;
	localparam logic [2:0] TRK_BEST         = 3'd1;
	localparam logic [2:0] TRK_GOOD         = 3'd2;
	localparam logic [2:0] TRK_TOOK_KF      = 3'd3;

	typedef struct packed {
		logic        init_mode;
		logic [15:0] move_time_ms;
		logic [15:0] wait_time_ms;
	} cfg_t;

	typedef struct packed {
		drive_t drive_choice;
		logic   send_takeoff;
		logic   reset_filter;
		logic   take_keyframe;
		logic   reset_tracker;
		logic   latch_target;
		logic   finished;
	} result_t;

endpackage

`default_nettype wire

[hdl/tis_if.sv]
`default_nettype none

// Input channel: one tick item.
interface tis_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic [2:0]  tracker_status;

	modport source (output valid, now_ms, tracker_status, input ready);
	modport sink (input valid, now_ms, tracker_status, output ready);
endinterface

// Output channel: one result item per tick.
interface tis_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] drive_choice;
	logic       send_takeoff;
	logic       reset_filter;
	logic       take_keyframe;
	logic       reset_tracker;
	logic       latch_target;
	logic       finished;

	modport source (output valid, drive_choice, send_takeoff, reset_filter, take_keyframe,
		reset_tracker, latch_target, finished, input ready);
	modport sink (input valid, drive_choice, send_takeoff, reset_filter, take_keyframe,
		reset_tracker, latch_target, finished, output ready);
endinterface

`default_nettype wire

[hdl/tis_cfg_regs.sv]
`default_nettype none

module tis_cfg_regs import tis_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic        init_mode_q;
	logic [15:0] move_time_q;
	logic [15:0] wait_time_q;
	logic        wr_en;
	reg_idx_t    idx;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// Register writes in the access phase; unmapped addresses are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_mode_q <= INIT_MODE_RST;
			move_time_q <= MOVE_TIME_RST;
			wait_time_q <= WAIT_TIME_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_INIT_MODE: init_mode_q <= pwdata[0];
				REG_MOVE_TIME: move_time_q <= pwdata[15:0];
				REG_WAIT_TIME: wait_time_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		unique case (idx)
			REG_INIT_MODE: prdata = {31'd0, init_mode_q};
			REG_MOVE_TIME: prdata = {16'd0, move_time_q};
			REG_WAIT_TIME: prdata = {16'd0, wait_time_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign cfg = '{init_mode: init_mode_q, move_time_ms: move_time_q,
		wait_time_ms: wait_time_q};

endmodule

`default_nettype wire

[hdl/tis_step.sv]
`default_nettype none

module tis_step import tis_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire logic [31:0] now_ms,
	input  wire logic [2:0]  tracker_status,
	input  wire cfg_t        cfg,
	output result_t          res
);

	stage_t      stage_q, stage_d;
	logic [31:0] start_q, start_d;
	logic        go_up_q, go_up_d;

	logic [31:0] el;
	logic [16:0] move_wait;
	logic        good, initializing;
	logic        plain_done, climb_done, first_done, second_to;
	logic        in_move, in_wait;

	// Elapsed time and the compares that drive every decision.
	assign el           = now_ms - start_q;
	assign move_wait    = {1'b0, cfg.move_time_ms} + {1'b0, cfg.wait_time_ms};
	assign good         = (tracker_status == TRK_BEST) || (tracker_status == TRK_GOOD) ||
		(tracker_status == TRK_TOOK_KF);
	assign initializing = (tracker_status == TRK_INITIALIZING);
	assign plain_done   = el >= PLAIN_WAIT_MS;
	assign climb_done   = el > CLIMB_WAIT_MS;
	assign first_done   = el > FIRST_WAIT_MS;
	assign second_to    = el >= SECOND_WAIT_MS;
	assign in_move      = el < {16'd0, cfg.move_time_ms};
	assign in_wait      = el < {15'd0, move_wait};

	// Next state.
	always_comb begin
		stage_d = stage_q;
		start_d = start_q;
		go_up_d = go_up_q;
		if (!cfg.init_mode) begin
			unique case (stage_q)
				ST_STARTED, ST_WAIT_FIRST, ST_TOOK_FIRST, ST_DONE: ;
				ST_WAIT_SECOND: begin
					if (plain_done) begin
						stage_d = ST_DONE;
					end
				end
				default: begin
					stage_d = ST_WAIT_SECOND;
					start_d = now_ms;
				end
			endcase
		end else begin
			unique case (stage_q)
				ST_STARTED: begin
					if (climb_done) begin
						stage_d = ST_WAIT_FIRST;
						start_d = now_ms;
					end
				end
				ST_WAIT_FIRST: begin
					if (first_done) begin
						stage_d = ST_TOOK_FIRST;
						start_d = now_ms;
					end
				end
				ST_TOOK_FIRST: begin
					if (!in_move && !in_wait) begin
						start_d = now_ms;
						if (initializing) begin
							stage_d = ST_WAIT_SECOND;
						end else begin
							stage_d = ST_WAIT_FIRST;
							go_up_d = !go_up_q;
						end
					end
				end
				ST_WAIT_SECOND: begin
					if (good) begin
						stage_d = ST_DONE;
					end else if (second_to) begin
						stage_d = ST_WAIT_FIRST;
						start_d = now_ms;
						go_up_d = !go_up_q;
					end
				end
				ST_DONE: ;
				default: begin
					stage_d = ST_STARTED;
					start_d = now_ms;
					go_up_d = 1'b1;
				end
			endcase
		end
	end

	// Result of this tick.
	always_comb begin
		res = '{drive_choice: DRV_HOVER, default: 1'b0};
		if (!cfg.init_mode) begin
			unique case (stage_q)
				ST_STARTED, ST_WAIT_FIRST, ST_TOOK_FIRST: ;
				ST_WAIT_SECOND: begin
					if (plain_done) begin
						res.latch_target = 1'b1;
						res.drive_choice = DRV_CTRL;
					end
				end
				ST_DONE: res.drive_choice = DRV_CTRL;
				default: res.send_takeoff = 1'b1;
			endcase
		end else begin
			unique case (stage_q)
				ST_STARTED: ;
				ST_WAIT_FIRST: res.take_keyframe = first_done;
				ST_TOOK_FIRST: begin
					if (in_move) begin
						res.drive_choice = go_up_q ? DRV_CLIMB : DRV_DESCEND;
					end else if (!in_wait) begin
						res.take_keyframe = initializing;
						res.reset_tracker = !initializing;
					end
				end
				ST_WAIT_SECOND: begin
					if (good) begin
						res.latch_target = 1'b1;
						res.drive_choice = DRV_CTRL;
					end else begin
						res.reset_tracker = second_to;
					end
				end
				ST_DONE: res.drive_choice = DRV_CTRL;
				default: begin
					res.send_takeoff = 1'b1;
					res.reset_filter = 1'b1;
				end
			endcase
		end
		res.finished = (stage_d == ST_DONE);
	end

	// Sequencer state advances once per tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_IDLE;
			start_q <= 32'd0;
			go_up_q <= 1'b0;
		end else if (advance) begin
			stage_q <= stage_d;
			start_q <= start_d;
			go_up_q <= go_up_d;
		end
	end

endmodule

`default_nettype wire

[hdl/takeoff_init_sequencer.sv]
// Takeoff and map initialization sequencer.
// The sample channel carries one tick item: a millisecond timestamp and a
// tracker status code. For every tick the result channel carries exactly one
// item: a drive choice, one-shot command pulses and the finished flag.
// Both channels use a valid/ready handshake; an item moves on a clock edge
// where valid and ready are both high.
// A tick accepted into the input register passes the stage logic and is shown
// from the result register. Throughput is one item per cycle while the receiver
// does not stall; the bound is the single stage update that each tick performs.
// When the receiver stalls, the result stays held and one more item is taken
// into the input register; after that sample.ready drops until the stall ends.
// Mode and timing registers sit on an APB port and should be written while no
// tick is in flight. Reset (arst_n low) returns the sequencer to its idle stage
// with init mode on and 1000 ms move and wait times, and empties both registers.
`default_nettype none
`include "takeoff_init_sequencer_macros.svh"

module takeoff_init_sequencer import tis_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	tis_in_if.sink                 sample,
	tis_out_if.source              result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	cfg_t        cfg;
	result_t     res_d;
	result_t     res_s2;
	logic        valid_s1;
	logic        valid_s2;
	logic [31:0] now_s1;
	logic [2:0]  status_s1;
	logic        advance;

	tis_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The held tick moves on when the result register is free or being read.
	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			now_s1    <= sample.now_ms;
			status_s1 <= sample.tracker_status;
		end
	end

	tis_step u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.now_ms         (now_s1),
		.tracker_status (status_s1),
		.cfg            (cfg),
		.res            (res_d)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid         = valid_s2;
	assign result.drive_choice  = res_s2.drive_choice;
	assign result.send_takeoff  = res_s2.send_takeoff;
	assign result.reset_filter  = res_s2.reset_filter;
	assign result.take_keyframe = res_s2.take_keyframe;
	assign result.reset_tracker = res_s2.reset_tracker;
	assign result.latch_target  = res_s2.latch_target;
	assign result.finished      = res_s2.finished;

	// A finished sequence always hands over to the position controller.
	`TIS_ASSERT_IMPL(a_done_ctrl, valid_s2 && res_s2.finished, res_s2.drive_choice == DRV_CTRL, "finished without controller drive")

	// A key frame, a tracker reset and a target latch never come on the same tick.
	`TIS_ASSERT_IMPL(a_pulse_excl, valid_s2, $onehot0({res_s2.take_keyframe, res_s2.reset_tracker, res_s2.latch_target}), "conflicting command pulses")

	// A stalled tick stays in the input register.
	`TIS_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1, "held tick lost during stall")

	// A tick that moves on always lands in the result register.
	`TIS_ASSERT_NEXT(a_s2_fill, advance, valid_s2, "tick dropped between registers")

endmodule

`default_nettype wire

[dv/tb_takeoff_init_sequencer.sv]
`timescale 1ns / 1ps

module tb_takeoff_init_sequencer;
	import tis_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	tis_in_if  sample_ch ();
	tis_out_if result_ch ();

	takeoff_init_sequencer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Sequencer state as the testbench tracks it, plus its copy of the registers.
	cfg_t        mode_cfg;
	stage_t      seq_stage;
	logic [31:0] seq_start;
	logic        seq_go_up;

	// Commands predicted for accepted ticks, oldest first.
	result_t     pending_cmds[$];
	logic [31:0] clock_ms;

	int tx_idle_max;
	int rx_idle_max;
	int rx_hold_cycles;
	int errors;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// End of the climb or descend plus the hover that follows it.
	function automatic logic [31:0] hover_end();
		return {16'd0, mode_cfg.move_time_ms} + {16'd0, mode_cfg.wait_time_ms};
	endfunction

	// Advances the tracked sequencer by one tick and returns the commands it issues.
	function automatic result_t sequence_tick(input logic [31:0] now, input logic [2:0] trk);
		result_t     r;
		logic [31:0] el;
		logic        good;
		r = '0;
		r.drive_choice = DRV_HOVER;
		el = now - seq_start;
		good = (trk == TRK_BEST) || (trk == TRK_GOOD) || (trk == TRK_TOOK_KF);
		// Codes past the done stage behave as idle.
		if (seq_stage > ST_DONE) seq_stage = ST_IDLE;

		if (!mode_cfg.init_mode) begin
			// Plain takeoff: take off, hover, then hand over to the controller.
			case (seq_stage)
				ST_IDLE: begin
					r.send_takeoff = 1'b1;
					seq_stage = ST_WAIT_SECOND;
					seq_start = now;
				end
				ST_WAIT_SECOND: begin
					if (el >= PLAIN_WAIT_MS) begin
						r.latch_target = 1'b1;
						r.drive_choice = DRV_CTRL;
						seq_stage = ST_DONE;
					end
				end
				ST_DONE: begin
					r.drive_choice = DRV_CTRL;
				end
				default: begin
					// Init-only stages simply hold in plain mode.
				end
			endcase
		end else begin
			case (seq_stage)
				ST_IDLE: begin
					r.send_takeoff = 1'b1;
					r.reset_filter = 1'b1;
					seq_go_up = 1'b1;
					seq_stage = ST_STARTED;
					seq_start = now;
				end
				ST_STARTED: begin
					if (el > CLIMB_WAIT_MS) begin
						seq_stage = ST_WAIT_FIRST;
						seq_start = now;
					end
				end
				ST_WAIT_FIRST: begin
					if (el > FIRST_WAIT_MS) begin
						r.take_keyframe = 1'b1;
						seq_stage = ST_TOOK_FIRST;
						seq_start = now;
					end
				end
				ST_TOOK_FIRST: begin
					if (el < {16'd0, mode_cfg.move_time_ms}) begin
						r.drive_choice = seq_go_up ? DRV_CLIMB : DRV_DESCEND;
					end else if (el < hover_end()) begin
						r.drive_choice = DRV_HOVER;
					end else if (trk == TRK_INITIALIZING) begin
						r.take_keyframe = 1'b1;
						seq_stage = ST_WAIT_SECOND;
						seq_start = now;
					end else begin
						// Tracker lost the map: retry in the other direction.
						seq_go_up = ~seq_go_up;
						r.reset_tracker = 1'b1;
						seq_stage = ST_WAIT_FIRST;
						seq_start = now;
					end
				end
				ST_WAIT_SECOND: begin
					if (good) begin
						r.latch_target = 1'b1;
						r.drive_choice = DRV_CTRL;
						seq_stage = ST_DONE;
					end else if (el >= SECOND_WAIT_MS) begin
						seq_go_up = ~seq_go_up;
						r.reset_tracker = 1'b1;
						seq_stage = ST_WAIT_FIRST;
						seq_start = now;
					end
				end
				default: begin
					r.drive_choice = DRV_CTRL;
				end
			endcase
		end
		r.finished = (seq_stage == ST_DONE);
		return r;
	endfunction

	// Offers one tick item after a random gap and records its predicted commands.
	// Valid is left high on return so that back-to-back items need no gap.
	task automatic send_tick(input logic [31:0] now, input logic [2:0] trk);
		int gap;
		gap = $urandom_range(0, tx_idle_max);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.now_ms <= now;
		sample_ch.tracker_status <= trk;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		pending_cmds.push_back(sequence_tick(now, trk));
		clock_ms = now;
		@(negedge clk);
	endtask

	// Sends a tick at a given time after the start of the current stage.
	task automatic tick_at(input logic [31:0] offset, input logic [2:0] trk);
		send_tick(seq_start + offset, trk);
	endtask

	// Writes a register once the sequencer has drained.
	task automatic set_reg(input reg_idx_t idx, input logic [31:0] value);
		sample_ch.valid <= 1'b0;
		while (pending_cmds.size() != 0) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_INIT_MODE: mode_cfg.init_mode = value[0];
			REG_MOVE_TIME: mode_cfg.move_time_ms = value[15:0];
			REG_WAIT_TIME: mode_cfg.wait_time_ms = value[15:0];
			default: begin
			end
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Random ticks that mostly walk time forward so the sequence keeps moving.
	// The done stage is never entered here, since nothing leaves it.
	task automatic fly_ticks(input int count);
		logic [31:0] now;
		logic [31:0] step_max;
		logic [2:0]  trk;
		repeat (count) begin
			step_max = (seq_stage == ST_TOOK_FIRST) ? hover_end() / 4 + 100 : 32'd1200;
			if ($urandom_range(0, 19) == 0) now = $urandom();
			else now = clock_ms + $urandom_range(0, step_max);
			trk = 3'($urandom_range(0, 7));
			if (seq_stage == ST_TOOK_FIRST && $urandom_range(0, 1) == 1)
				trk = TRK_INITIALIZING;
			if (seq_stage == ST_WAIT_SECOND) begin
				if (mode_cfg.init_mode) begin
					if (trk == TRK_BEST || trk == TRK_GOOD || trk == TRK_TOOK_KF)
						trk = ($urandom_range(0, 1) == 1) ? TRK_INITIALIZING
							: 3'($urandom_range(4, 7));
				end else begin
					now = seq_start + $urandom_range(0, PLAIN_WAIT_MS - 1);
				end
			end
			send_tick(now, trk);
		end
	endtask

	function automatic logic [15:0] pick_time();
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(1, 3000));
		endcase
	endfunction

	// Takeoff in one of the two modes, starting just short of the time wrap.
	task automatic test_opening();
		if ($urandom_range(0, 1) == 1) begin
			set_reg(REG_INIT_MODE, 32'd0);
			send_tick(32'hFFFF_F000, TRK_INITIALIZING);
			tick_at(PLAIN_WAIT_MS - 1, TRK_GOOD);
			// The hover stage is shared, so init rules take over after the switch.
			set_reg(REG_INIT_MODE, 32'd1);
			tick_at(SECOND_WAIT_MS - 1, 3'd4);
			tick_at(SECOND_WAIT_MS, TRK_INITIALIZING);
		end else begin
			set_reg(REG_INIT_MODE, 32'd1);
			send_tick(32'hFFFF_F000, TRK_TOOK_KF);
			// Plain mode freezes the init-only stages.
			set_reg(REG_INIT_MODE, 32'd0);
			tick_at(CLIMB_WAIT_MS + 1000, TRK_INITIALIZING);
			set_reg(REG_INIT_MODE, 32'd1);
			tick_at(CLIMB_WAIT_MS, 3'd4);
			tick_at(CLIMB_WAIT_MS + 1, TRK_INITIALIZING);
		end
	endtask

	// Walks key frames, both move directions, retries and the hover edges.
	task automatic test_init_stages();
		set_reg(REG_INIT_MODE, 32'd0);
		tick_at(5000, TRK_GOOD);
		set_reg(REG_INIT_MODE, 32'd1);
		tick_at(FIRST_WAIT_MS, TRK_INITIALIZING);
		tick_at(FIRST_WAIT_MS + 1, TRK_BEST);
		set_reg(REG_INIT_MODE, 32'd0);
		tick_at(500, TRK_INITIALIZING);
		set_reg(REG_INIT_MODE, 32'd1);
		tick_at(0, TRK_INITIALIZING);
		tick_at(999, TRK_INITIALIZING);
		tick_at(1000, TRK_INITIALIZING);
		tick_at(1999, TRK_INITIALIZING);
		tick_at(2000, 3'd4);
		tick_at(FIRST_WAIT_MS + 1, TRK_INITIALIZING);
		tick_at(500, TRK_GOOD);
		tick_at(2000, TRK_INITIALIZING);
		tick_at(SECOND_WAIT_MS - 1, 3'd5);
		tick_at(SECOND_WAIT_MS, 3'd7);
	endtask

	// Zero and full-scale move and wait times.
	task automatic test_time_extremes();
		set_reg(REG_MOVE_TIME, 32'd0);
		set_reg(REG_WAIT_TIME, 32'd0);
		tick_at(FIRST_WAIT_MS + 1, TRK_INITIALIZING);
		tick_at(0, TRK_INITIALIZING);
		tick_at(SECOND_WAIT_MS, 3'd6);
		tick_at(FIRST_WAIT_MS + 1, TRK_INITIALIZING);
		tick_at(0, TRK_TOOK_KF);
		set_reg(REG_MOVE_TIME, 32'hFFFF);
		set_reg(REG_WAIT_TIME, 32'hFFFF);
		tick_at(FIRST_WAIT_MS + 1, TRK_INITIALIZING);
		tick_at(32'd65534, TRK_INITIALIZING);
		tick_at(32'd65535, TRK_INITIALIZING);
		tick_at(32'd131069, TRK_INITIALIZING);
		tick_at(32'd131070, TRK_INITIALIZING);
	endtask

	// The receiver stalls for a long stretch while ticks keep coming.
	task automatic test_backpressure();
		tx_idle_max = 0;
		rx_idle_max = 0;
		rx_hold_cycles = 120;
		fly_ticks(40);
		tx_idle_max = 19;
		rx_idle_max = 19;
	endtask

	// Phases of random flight under changing timing, mode and idling.
	task automatic test_random_flight();
		logic plain;
		for (int phase = 0; phase < 13; phase++) begin
			plain = (phase >= 2) && ($urandom_range(0, 3) == 0);
			set_reg(REG_INIT_MODE, plain ? 32'd0 : 32'd1);
			if (phase == 0) begin
				set_reg(REG_MOVE_TIME, 32'hFFFF);
				set_reg(REG_WAIT_TIME, 32'hFFFF);
				tx_idle_max = 19;
				rx_idle_max = 19;
			end else if (phase == 1) begin
				set_reg(REG_MOVE_TIME, 32'd0);
				set_reg(REG_WAIT_TIME, 32'd0);
				tx_idle_max = 0;
				rx_idle_max = 0;
			end else begin
				set_reg(REG_MOVE_TIME, {16'd0, pick_time()});
				set_reg(REG_WAIT_TIME, {16'd0, pick_time()});
				tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
				rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
			end
			fly_ticks(plain ? 40 : 170);
		end
		tx_idle_max = 19;
		rx_idle_max = 19;
	endtask

	// Reaches the done stage by one of the two hand-over paths and stays there.
	task automatic test_finish();
		logic close_plain;
		close_plain = $urandom_range(0, 1);
		set_reg(REG_INIT_MODE, 32'd1);
		while (seq_stage != ST_WAIT_SECOND) begin
			case (seq_stage)
				ST_STARTED: tick_at(CLIMB_WAIT_MS + 1, TRK_INITIALIZING);
				ST_WAIT_FIRST: tick_at(FIRST_WAIT_MS + 1, TRK_INITIALIZING);
				default: tick_at(hover_end(), TRK_INITIALIZING);
			endcase
		end
		if (close_plain) begin
			set_reg(REG_INIT_MODE, 32'd0);
			tick_at(PLAIN_WAIT_MS - 1, TRK_GOOD);
			tick_at(PLAIN_WAIT_MS, TRK_INITIALIZING);
		end else begin
			tick_at(SECOND_WAIT_MS - 1, TRK_INITIALIZING);
			tick_at(100, 3'($urandom_range(1, 3)));
		end
		fly_ticks(4);
		set_reg(REG_INIT_MODE, {31'd0, close_plain});
		fly_ticks(4);
	endtask

	// Result receiver: a random stall before each item, plus any requested hold-off.
	initial begin : result_sink
		int stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, rx_idle_max) + rx_hold_cycles;
			rx_hold_cycles = 0;
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!(result_ch.valid && result_ch.ready)) @(posedge clk);
			@(negedge clk);
		end
	end

	// Compares each delivered item with the oldest predicted commands.
	always @(posedge clk) begin : cmd_check
		result_t got;
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.drive_choice = drive_t'(result_ch.drive_choice);
			got.send_takeoff = result_ch.send_takeoff;
			got.reset_filter = result_ch.reset_filter;
			got.take_keyframe = result_ch.take_keyframe;
			got.reset_tracker = result_ch.reset_tracker;
			got.latch_target = result_ch.latch_target;
			got.finished = result_ch.finished;
			if (pending_cmds.size() == 0) begin
				if (errors < 10) $display("result item with no tick pending: %b", got);
				errors++;
			end else begin
				want = pending_cmds.pop_front();
				if (got !== want) begin
					if (errors < 10)
						$display({"mismatch: expected drive %0d tk/rf/kf/rt/lt %b%b%b%b%b",
							" fin %b, got drive %0d tk/rf/kf/rt/lt %b%b%b%b%b fin %b"},
							want.drive_choice, want.send_takeoff, want.reset_filter,
							want.take_keyframe, want.reset_tracker, want.latch_target,
							want.finished, got.drive_choice, got.send_takeoff,
							got.reset_filter, got.take_keyframe, got.reset_tracker,
							got.latch_target, got.finished);
					errors++;
				end
			end
		end
	end

	initial begin : run
		int waited;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.now_ms = '0;
		sample_ch.tracker_status = '0;
		mode_cfg.init_mode = INIT_MODE_RST;
		mode_cfg.move_time_ms = MOVE_TIME_RST;
		mode_cfg.wait_time_ms = WAIT_TIME_RST;
		seq_stage = ST_IDLE;
		seq_start = '0;
		seq_go_up = 1'b0;
		clock_ms = '0;
		tx_idle_max = 19;
		rx_idle_max = 19;
		rx_hold_cycles = 0;
		errors = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_opening();
		test_init_stages();
		test_time_extremes();
		test_backpressure();
		test_random_flight();
		test_finish();

		// Let the last items drain, then keep watching for stray results.
		sample_ch.valid <= 1'b0;
		waited = 0;
		while (pending_cmds.size() != 0 && waited < 2000) begin
			@(negedge clk);
			waited++;
		end
		repeat (6) @(negedge clk);
		if (pending_cmds.size() != 0) begin
			if (errors < 10) $display("%0d ticks never produced a result", pending_cmds.size());
			errors++;
		end
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin : watchdog
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
